// ----- design/hcbd_pkg.sv -----
// Shared types and constants for the chunked body decoder.
`default_nettype none
package hcbd_pkg;

   localparam int LEN_BITS    = 32;
   localparam int HDR_BITS    = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [HDR_BITS-1:0] HDR_MAX = HDR_BITS'(20);

   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_HT    = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF_HX = 8'h66;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;

   typedef enum logic [1:0] {
      K_DATA  = 2'd0,
      K_END   = 2'd1,
      K_BEGIN = 2'd2,
      K_NONE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_BUSY = 3'd0,
      ST_DONE = 3'd1,
      ST_READ = 3'd2,
      ST_LONG = 3'd3,
      ST_CHAR = 3'd4,
      ST_NUM  = 3'd5,
      ST_TAIL = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_LEAD   = 3'd1,
      PH_DIGITS = 3'd2,
      PH_TRAIL  = 3'd3,
      PH_BODY   = 3'd4,
      PH_TAIL1  = 3'd5,
      PH_TAIL2  = 3'd6
   } phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic        is_hex;
      logic [3:0]  hex_digit;
      logic        is_ws;
      logic        is_lf;
      logic        is_cr;
      logic        is_plus;
      logic        is_zero;
   } class_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage
`default_nettype wire

// ----- design/hcbd_front.sv -----
// Front end: classifies each accepted beat into a decoded byte class.
`default_nettype none
module hcbd_front (
   input  wire logic [1:0]          req_kind,
   input  wire logic [7:0]          req_data_byte,
   output hcbd_pkg::class_type      item
);
   import hcbd_pkg::*;

   logic is_dec;
   logic is_low;
   logic is_up;

   assign is_dec = (req_data_byte >= CH_ZERO) && (req_data_byte <= CH_NINE);
   assign is_low = (req_data_byte >= CH_LA) && (req_data_byte <= CH_LF_HX);
   assign is_up  = (req_data_byte >= CH_UA) && (req_data_byte <= CH_UF);

   always_comb begin
      item.kind      = kind_type'(req_kind);
      item.data_byte = req_data_byte;
      item.is_hex    = is_dec | is_low | is_up;
      if (is_dec) begin
         item.hex_digit = req_data_byte[3:0];
      end else if (is_low || is_up) begin
         item.hex_digit = 4'(req_data_byte[2:0] + 3'd1) + 4'd8;
      end else begin
         item.hex_digit = 4'd0;
      end
      item.is_ws   = (req_data_byte == CH_SP) || (req_data_byte == CH_HT)
                     || (req_data_byte == CH_CR);
      item.is_lf   = (req_data_byte == CH_LF);
      item.is_cr   = (req_data_byte == CH_CR);
      item.is_plus = (req_data_byte == CH_PLUS);
      item.is_zero = (req_data_byte == CH_ZERO);
   end

endmodule
`default_nettype wire

// ----- design/hcbd_queue.sv -----
// Short queue of classified beats between front end and back end.
`default_nettype none
module hcbd_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire hcbd_pkg::class_type       push_item,
   input  wire logic                      pop,
   output hcbd_pkg::class_type            pop_item,
   output hcbd_pkg::queue_status_type     stat
);
   import hcbd_pkg::*;

   class_type                store_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item   = store_ff[rd_ptr_ff];
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));

endmodule
`default_nettype wire

// ----- design/hcbd_back.sv -----
// Back end: chunk framing state machine and result register.
`default_nettype none
module hcbd_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire hcbd_pkg::class_type       item,
   input  wire logic                      item_ready,
   output logic                           pop,
   input  wire logic                      rsp_stall,
   output logic                           rsp_valid,
   output logic [7:0]                     rsp_body_byte,
   output logic                           rsp_body_valid,
   output logic [2:0]                     rsp_status
);
   import hcbd_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [HDR_BITS-1:0]    header_count_ff, header_count_in;
   logic                   first_was_zero_ff, first_was_zero_in;
   logic                   sign_seen_ff, sign_seen_in;
   logic                   size_overflow_ff, size_overflow_in;
   logic [LEN_BITS-1:0]    chunk_ff, chunk_in;
   logic                   last_nonzero_ff, last_nonzero_in;
   logic                   lead_bad_ff, lead_bad_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             body_byte_ff;
   logic                   body_valid_ff;
   status_type             status_ff;

   logic                   restart;
   logic                   do_add;
   logic                   line_err;
   logic                   skip_zero;
   logic [HDR_BITS-1:0]    hc_next;
   logic                   chunk_nonzero;
   logic                   chunk_last;

   status_type             st;
   logic                   valid;
   logic [7:0]             obyte;

   assign pop           = item_ready && (!rsp_valid_ff || !rsp_stall);
   assign line_err      = lead_bad_ff || size_overflow_ff
                          || (sign_seen_ff && (header_count_ff == HDR_BITS'(1)));
   assign skip_zero     = (header_count_ff == HDR_BITS'(1)) && first_was_zero_ff
                          && item.is_zero;
   assign hc_next       = header_count_ff + HDR_BITS'(1);
   assign chunk_nonzero = (chunk_ff != '0);
   assign chunk_last    = (chunk_ff == LEN_BITS'(1));

   // next state
   always_comb begin
      phase_in          = phase_ff;
      header_count_in   = header_count_ff;
      first_was_zero_in = first_was_zero_ff;
      sign_seen_in      = sign_seen_ff;
      size_overflow_in  = size_overflow_ff;
      chunk_in          = chunk_ff;
      last_nonzero_in   = last_nonzero_ff;
      lead_bad_in       = lead_bad_ff;
      restart           = 1'b0;
      do_add            = 1'b0;
      if (pop) begin
         unique case (item.kind)
            K_BEGIN: begin
               restart         = 1'b1;
               last_nonzero_in = 1'b0;
            end
            K_END: begin
               phase_in = PH_IDLE;
            end
            K_DATA: begin
               unique case (phase_ff)
                  PH_LEAD: begin
                     if (!(item.is_ws || item.is_lf)) begin
                        header_count_in = HDR_BITS'(1);
                        phase_in        = PH_DIGITS;
                        if (item.is_hex) begin
                           do_add            = 1'b1;
                           first_was_zero_in = item.is_zero;
                        end else if (item.is_plus) begin
                           sign_seen_in = 1'b1;
                        end else begin
                           lead_bad_in = 1'b1;
                        end
                     end
                  end
                  PH_DIGITS: begin
                     if (skip_zero) begin
                        phase_in = PH_DIGITS;
                     end else if (item.is_hex) begin
                        do_add          = 1'b1;
                        header_count_in = hc_next;
                        if (hc_next >= HDR_MAX) begin
                           phase_in = PH_IDLE;
                        end
                     end else if (item.is_lf) begin
                        if (line_err) begin
                           phase_in = PH_IDLE;
                        end else begin
                           last_nonzero_in = chunk_nonzero;
                           phase_in        = chunk_nonzero ? PH_BODY : PH_TAIL1;
                        end
                     end else if (item.is_ws) begin
                        phase_in = PH_TRAIL;
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
                  PH_TRAIL: begin
                     if (item.is_lf) begin
                        if (line_err) begin
                           phase_in = PH_IDLE;
                        end else begin
                           last_nonzero_in = chunk_nonzero;
                           phase_in        = chunk_nonzero ? PH_BODY : PH_TAIL1;
                        end
                     end else if (!item.is_ws) begin
                        phase_in = PH_IDLE;
                     end
                  end
                  PH_BODY: begin
                     chunk_in = chunk_ff - LEN_BITS'(1);
                     if (chunk_last) begin
                        phase_in = PH_TAIL1;
                     end
                  end
                  PH_TAIL1: begin
                     if (item.is_cr) begin
                        phase_in = PH_TAIL2;
                     end else if (item.is_lf) begin
                        if (last_nonzero_ff) begin
                           restart = 1'b1;
                        end else begin
                           phase_in = PH_IDLE;
                        end
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
                  PH_TAIL2: begin
                     if (item.is_lf && last_nonzero_ff) begin
                        restart = 1'b1;
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
      if (do_add && !size_overflow_ff) begin
         if (chunk_ff[LEN_BITS-1 -: 4] != 4'd0) begin
            size_overflow_in = 1'b1;
         end else begin
            chunk_in = {chunk_ff[LEN_BITS-5:0], item.hex_digit};
         end
      end
      if (restart) begin
         phase_in          = PH_LEAD;
         header_count_in   = '0;
         first_was_zero_in = 1'b0;
         sign_seen_in      = 1'b0;
         size_overflow_in  = 1'b0;
         lead_bad_in       = 1'b0;
         chunk_in          = '0;
      end
   end

   // result of the beat
   always_comb begin
      st    = ST_BUSY;
      valid = 1'b0;
      obyte = 8'd0;
      unique case (item.kind)
         K_END: begin
            if (phase_ff != PH_IDLE) begin
               st = ST_READ;
            end
         end
         K_DATA: begin
            unique case (phase_ff)
               PH_DIGITS: begin
                  if (skip_zero) begin
                     st = ST_BUSY;
                  end else if (item.is_hex) begin
                     if (hc_next >= HDR_MAX) begin
                        st = ST_LONG;
                     end
                  end else if (item.is_lf) begin
                     if (line_err) begin
                        st = ST_NUM;
                     end
                  end else if (!item.is_ws) begin
                     st = ST_CHAR;
                  end
               end
               PH_TRAIL: begin
                  if (item.is_lf) begin
                     if (line_err) begin
                        st = ST_NUM;
                     end
                  end else if (!item.is_ws) begin
                     st = ST_CHAR;
                  end
               end
               PH_BODY: begin
                  valid = 1'b1;
                  obyte = item.data_byte;
               end
               PH_TAIL1: begin
                  if (item.is_lf) begin
                     if (!last_nonzero_ff) begin
                        st = ST_DONE;
                     end
                  end else if (!item.is_cr) begin
                     st = ST_TAIL;
                  end
               end
               PH_TAIL2: begin
                  if (item.is_lf) begin
                     if (!last_nonzero_ff) begin
                        st = ST_DONE;
                     end
                  end else begin
                     st = ST_TAIL;
                  end
               end
               default: begin
                  st = ST_BUSY;
               end
            endcase
         end
         default: begin
            st = ST_BUSY;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         header_count_ff   <= '0;
         first_was_zero_ff <= 1'b0;
         sign_seen_ff      <= 1'b0;
         size_overflow_ff  <= 1'b0;
         chunk_ff          <= '0;
         last_nonzero_ff   <= 1'b0;
         lead_bad_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         header_count_ff   <= header_count_in;
         first_was_zero_ff <= first_was_zero_in;
         sign_seen_ff      <= sign_seen_in;
         size_overflow_ff  <= size_overflow_in;
         chunk_ff          <= chunk_in;
         last_nonzero_ff   <= last_nonzero_in;
         lead_bad_ff       <= lead_bad_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         body_byte_ff  <= obyte;
         body_valid_ff <= valid;
         status_ff     <= st;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_body_byte  = body_byte_ff;
   assign rsp_body_valid = body_valid_ff;
   assign rsp_status     = status_ff;

endmodule
`default_nettype wire

// ----- design/http_chunked_body_decoder.sv -----
// HTTP/1.1 chunked body decoder: top level.
// An accepted beat is written into the queue; the back end registers its result when it pops it.
// Throughput: one beat per cycle while rsp_stall is low, as the back end
// pops one beat from the two-entry queue each cycle while it is not empty.
// Reset: synchronous; phase idle, queue empty, no result pending.
`default_nettype none
module http_chunked_body_decoder (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [1:0]    req_kind,
   input  wire logic [7:0]    req_data_byte,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [7:0]         rsp_body_byte,
   output logic               rsp_body_valid,
   output logic [2:0]         rsp_status
);
   import hcbd_pkg::*;

   class_type          front_item;
   class_type          back_item;
   queue_status_type   q_stat;
   logic               push;
   logic               pop;

   assign req_stall = q_stat.full;
   assign push      = req_valid && !q_stat.full;

   hcbd_front u_front (
      .req_kind      (req_kind),
      .req_data_byte (req_data_byte),
      .item          (front_item)
   );

   hcbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .pop_item  (back_item),
      .stat      (q_stat)
   );

   hcbd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .item           (back_item),
      .item_ready     (!q_stat.empty),
      .pop            (pop),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_body_byte  (rsp_body_byte),
      .rsp_body_valid (rsp_body_valid),
      .rsp_status     (rsp_status)
   );

   a_payload_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_body_valid) |-> (rsp_status == ST_BUSY))
      else $error("payload beat with non-busy status");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (push && q_stat.empty && !rsp_valid) |-> ##2 rsp_valid)
      else $error("result beat missing two cycles after accept");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && q_stat.empty) |=> !rsp_valid)
      else $error("result beat invented with empty queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_stat.empty |-> !pop)
      else $error("pop from empty queue");

endmodule
`default_nettype wire
